[design/bcpd_pkg.sv]
// Shared types, codes and widths of the button click pattern detector.
package bcpd_pkg;

  localparam int unsigned TimeBits  = 32;
  localparam int unsigned TickBits  = 16;
  localparam int unsigned CountBits = 4;
  localparam int unsigned DurBits   = 32;
  localparam int unsigned EventBits = 3;
  localparam int unsigned PhaseBits = 2;
  localparam int unsigned CfgIdxBits = 2;

  typedef logic [TimeBits-1:0]   time_t;
  typedef logic [TickBits-1:0]   ticks_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [DurBits-1:0]    dur_t;
  typedef logic [EventBits-1:0]  event_t;
  typedef logic [PhaseBits-1:0]  phase_t;
  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  // debounce phases
  localparam phase_t PhaseIdle     = 2'd0;
  localparam phase_t PhaseDebounce = 2'd1;
  localparam phase_t PhaseHeld     = 2'd2;
  localparam phase_t PhaseLong     = 2'd3;

  // event codes
  localparam event_t EvNone    = 3'd0;
  localparam event_t EvPress   = 3'd4;
  localparam event_t EvRelease = 3'd7;

  // configuration register indexes
  localparam cfg_idx_t CfgDebounceTicks = 2'd0;
  localparam cfg_idx_t CfgWindowTicks   = 2'd1;
  localparam cfg_idx_t CfgReleasedLevel = 2'd2;

  localparam count_t CountMax      = 4'd15;
  localparam ticks_t DebounceReset = 16'd50;
  localparam ticks_t WindowReset   = 16'd500;

  typedef struct packed {
    ticks_t debounce_ticks;
    ticks_t window_ticks;
    logic   released_level;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    count_t click_count;
    logic   held_flag;
    time_t  tick_time;
    time_t  debounce_start;
    time_t  window_start;
    time_t  press_start;
    time_t  press_stop;
  } state_t;

  typedef struct packed {
    event_t event_code;
    dur_t   pressed_duration;
  } result_t;

endpackage

[design/bcpd_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface bcpd_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic pin_level;

  modport source (output valid, output cmd, output pin_level, input ready);
  modport sink   (input valid, input cmd, input pin_level, output ready);
endinterface

interface bcpd_out_if;
  logic                  valid;
  logic                  ready;
  bcpd_pkg::event_t      event_code;
  bcpd_pkg::dur_t        pressed_duration;

  modport source (output valid, output event_code, output pressed_duration, input ready);
  modport sink   (input valid, input event_code, input pressed_duration, output ready);
endinterface

[design/bcpd_step.sv]
// Next-state and result logic for one tick or clear item.
module bcpd_step (
  input  bcpd_pkg::cfg_t    cfg_i,
  input  bcpd_pkg::state_t  state_i,
  input  logic              cmd_i,
  input  logic              pin_level_i,
  output bcpd_pkg::state_t  state_o,
  output bcpd_pkg::result_t result_o
);

  bcpd_pkg::state_t nxt;
  bcpd_pkg::event_t ev;
  bcpd_pkg::time_t  now;
  bcpd_pkg::time_t  win_elapsed;
  bcpd_pkg::time_t  deb_elapsed;
  logic             released;

  assign now         = state_i.tick_time;
  assign released    = (pin_level_i == cfg_i.released_level);
  assign win_elapsed = now - state_i.window_start;
  assign deb_elapsed = now - state_i.debounce_start;

  always_comb begin
    nxt = state_i;
    ev  = bcpd_pkg::EvNone;
    if (cmd_i) begin
      // clear everything but the time base, which holds
      nxt           = '0;
      nxt.tick_time = state_i.tick_time;
    end else begin
      // judge the window
      if (state_i.click_count != '0 || state_i.phase == bcpd_pkg::PhaseHeld) begin
        if (win_elapsed >= bcpd_pkg::time_t'(cfg_i.window_ticks)) begin
          if (released) begin
            if (state_i.click_count inside {[4'd1:4'd3]}) begin
              ev = bcpd_pkg::event_t'(state_i.click_count);
            end
          end else begin
            if (state_i.click_count <= 4'd2) begin
              ev = bcpd_pkg::EvPress + bcpd_pkg::event_t'(state_i.click_count);
            end
            nxt.press_start = now;
            nxt.phase       = bcpd_pkg::PhaseLong;
          end
          nxt.click_count    = '0;
          nxt.debounce_start = '0;
          nxt.window_start   = '0;
        end
      end

      // debounce machine sees the phase left by the judgement
      case (nxt.phase)
        bcpd_pkg::PhaseIdle: begin
          if (!released && !nxt.held_flag) begin
            nxt.debounce_start = now;
            if (nxt.click_count == '0) begin
              nxt.window_start = now;
            end
            nxt.held_flag = 1'b1;
            nxt.phase     = bcpd_pkg::PhaseDebounce;
          end
        end
        bcpd_pkg::PhaseDebounce: begin
          if (deb_elapsed >= bcpd_pkg::time_t'(cfg_i.debounce_ticks) && !released) begin
            nxt.phase = bcpd_pkg::PhaseHeld;
          end
        end
        bcpd_pkg::PhaseHeld: begin
          if (released) begin
            if (nxt.click_count < bcpd_pkg::CountMax) begin
              nxt.click_count = nxt.click_count + 1'b1;
            end
            nxt.held_flag = 1'b0;
            nxt.phase     = bcpd_pkg::PhaseIdle;
          end
        end
        bcpd_pkg::PhaseLong: begin
          if (released) begin
            nxt.held_flag  = 1'b0;
            nxt.phase      = bcpd_pkg::PhaseIdle;
            nxt.press_stop = now;
            ev             = bcpd_pkg::EvRelease;
          end
        end
        default: begin
          nxt.phase = bcpd_pkg::PhaseIdle;
        end
      endcase

      nxt.tick_time = state_i.tick_time + 1'b1;
    end
  end

  assign state_o                   = nxt;
  assign result_o.event_code       = ev;
  assign result_o.pressed_duration = bcpd_pkg::dur_t'(nxt.press_stop - nxt.press_start);

endmodule

[design/button_click_pattern_detector_unit.sv]
// Top level of the button click pattern detector: state, config, output buffering.
// Usage:
//   in_ch carries one item per millisecond tick: cmd = 0 with the sampled pin
//   level, or cmd = 1 to clear the detector (the tick counter holds).
//   out_ch returns exactly one result per item: event_code and the duration of
//   the last long press.
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write debounce_ticks (0), window_ticks (1)
//   and released_level (2); write only while no item is in flight.
// Timing:
//   The step logic is combinational; a result is registered in the output
//   register or skid entry. One item per cycle is sustained while out_ch.ready
//   is high; the limit is the single state register update per tick.
//   Results sit in an output register backed by one skid entry, so in_ch.ready
//   depends only on the skid entry and one item is still taken while a result
//   waits. With both full, in_ch.ready drops until out_ch.ready returns.
// Reset:
//   rst_ni clears detector state, the tick counter and both output entries, and
//   loads the registers with debounce 50, window 500, released level 0.
module button_click_pattern_detector_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bcpd_in_if.sink                in_ch,
  bcpd_out_if.source             out_ch,
  input  logic                   cfg_we_i,
  input  bcpd_pkg::cfg_idx_t     cfg_idx_i,
  input  bcpd_pkg::ticks_t       cfg_wdata_i
);

  bcpd_pkg::cfg_t    cfg_q;
  bcpd_pkg::state_t  state_q, state_d;
  bcpd_pkg::result_t step_res;
  bcpd_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              in_fire, out_fire;

  assign in_ch.ready = !skid_valid_q;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_q && out_ch.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= bcpd_pkg::DebounceReset;
      cfg_q.window_ticks   <= bcpd_pkg::WindowReset;
      cfg_q.released_level <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcpd_pkg::CfgDebounceTicks: cfg_q.debounce_ticks <= cfg_wdata_i;
        bcpd_pkg::CfgWindowTicks:   cfg_q.window_ticks   <= cfg_wdata_i;
        bcpd_pkg::CfgReleasedLevel: cfg_q.released_level <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  bcpd_step u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .cmd_i       (in_ch.cmd),
    .pin_level_i (in_ch.pin_level),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  // detector state advances once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ch.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ch.ready) begin
        skid_q <= step_res;
      end else begin
        out_q <= step_res;
      end
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.event_code       = out_q.event_code;
  assign out_ch.pressed_duration = out_q.pressed_duration;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a valid output entry");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_ch.cmd |=> state_q.phase == bcpd_pkg::PhaseIdle &&
      state_q.click_count == '0 && !state_q.held_flag)
    else $error("clear item did not return detector to idle");

  a_tick_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_ch.cmd |=>
      state_q.tick_time == bcpd_pkg::time_t'($past(state_q.tick_time) + 1'b1))
    else $error("tick counter did not advance by one");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item left no result");

endmodule
